@@ sv/pie_aqm_pkg.sv @@
// Shared types and constants of the PIE drop controller.
// No dependencies; the top level, sequencer, datapath and checker take names from here by scope.
package pie_aqm_pkg;

    localparam logic [24:0] PROB_ONE    = 25'd16777216;
    localparam logic [24:0] PROB_LT_001 = 25'd167773;
    localparam logic [24:0] PROB_LT_01  = 25'd1677722;
    localparam logic [24:0] PROB_LT_02  = 25'd3355444;
    localparam logic [10:0] REPLAY_LIMIT = 11'd1024;
    // floor(z / 25) = (z * DECAY_RECIP) >> 34 for every z below 2^29
    localparam logic [29:0] DECAY_RECIP = 30'd687194768;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT = 2'd0,
        VERDICT_FULL   = 2'd1,
        VERDICT_EARLY  = 2'd2,
        VERDICT_DEQ    = 2'd3
    } t_verdict;

    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_BURST  = 3'd1,
        REG_PERIOD = 3'd2,
        REG_THRESH = 3'd3,
        REG_BLIMIT = 3'd4,
        REG_PLIMIT = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAS,
        ST_MCHK,
        ST_MDIV,
        ST_MUPD,
        ST_RSTART,
        ST_RDIV,
        ST_RCHK,
        ST_PA,
        ST_PB,
        ST_PC,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [15:0] target;
        logic [15:0] burst;
        logic [9:0]  period;
        logic [31:0] thresh;
        logic [31:0] blimit;
        logic [31:0] plimit;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic meas;
        logic mdiv_start;
        logic mupd;
        logic rstart;
        logic rdiv_start;
        logic rskip;
        logic per_a;
        logic per_b;
        logic per_c;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic action;
        logic started;
        logic meas_due;
        logic avg_nz;
        logic rep_more;
        logic rep_limit;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

@@ sv/pie_aqm_in_if.sv @@
// Input event channel: valid/ready handshake with the event fields.
// Depends on nothing.
interface pie_aqm_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] now_ms;
    logic [15:0] packet_bytes;
    logic [31:0] queue_bytes;
    logic [31:0] queue_packets;
    logic [23:0] random_fraction;

    modport source (output valid, action, now_ms, packet_bytes, queue_bytes,
                    queue_packets, random_fraction, input ready);
    modport sink   (input valid, action, now_ms, packet_bytes, queue_bytes,
                    queue_packets, random_fraction, output ready);
endinterface

@@ sv/pie_aqm_out_if.sv @@
// Result channel: valid/ready handshake with verdict and controller status.
// Depends on nothing.
interface pie_aqm_out_if;
    logic        valid;
    logic        ready;
    logic        accept;
    logic [1:0]  verdict;
    logic [24:0] drop_probability;
    logic [31:0] queue_delay_ms;
    logic [31:0] dequeue_rate;

    modport source (output valid, accept, verdict, drop_probability,
                    queue_delay_ms, dequeue_rate, input ready);
    modport sink   (input valid, accept, verdict, drop_probability,
                    queue_delay_ms, dequeue_rate, output ready);
endinterface

@@ sv/pie_aqm_drop_controller.sv @@
// An event is captured, then a dequeue updates the byte count and takes a rate sample
// through the divider when one is due; the delay estimate is divided when update periods
// are due and the rate is non-zero, and each replayed period runs stages A, B and C;
// the result is held while the sink stalls. Events are taken one at a time, only when idle.
// Reset: synchronous, active low; clears controller state, loads register defaults.
module pie_aqm_drop_controller #(
    parameter int unsigned MIN_QUEUE_BYTES_HALF = 1504
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    pie_aqm_in_if.sink  i_in,
    pie_aqm_out_if.source o_out
);
    pie_aqm_pkg::t_cfg r_cfg;
    pie_aqm_pkg::t_cmd w_cmd;
    pie_aqm_pkg::t_sts w_sts;
    pie_aqm_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_idx  = pie_aqm_pkg::t_reg_idx'(paddr[4:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target <= 16'd20;
            r_cfg.burst  <= 16'd100;
            r_cfg.period <= 10'd30;
            r_cfg.thresh <= 32'd16384;
            r_cfg.blimit <= 32'd0;
            r_cfg.plimit <= 32'd0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                pie_aqm_pkg::REG_TARGET: r_cfg.target <= pwdata[15:0];
                pie_aqm_pkg::REG_BURST:  r_cfg.burst  <= pwdata[15:0];
                pie_aqm_pkg::REG_PERIOD: r_cfg.period <= pwdata[9:0];
                pie_aqm_pkg::REG_THRESH: r_cfg.thresh <= pwdata;
                pie_aqm_pkg::REG_BLIMIT: r_cfg.blimit <= pwdata;
                pie_aqm_pkg::REG_PLIMIT: r_cfg.plimit <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (w_idx)
            pie_aqm_pkg::REG_TARGET: prdata = {16'd0, r_cfg.target};
            pie_aqm_pkg::REG_BURST:  prdata = {16'd0, r_cfg.burst};
            pie_aqm_pkg::REG_PERIOD: prdata = {22'd0, r_cfg.period};
            pie_aqm_pkg::REG_THRESH: prdata = r_cfg.thresh;
            pie_aqm_pkg::REG_BLIMIT: prdata = r_cfg.blimit;
            pie_aqm_pkg::REG_PLIMIT: prdata = r_cfg.plimit;
            default:                 prdata = 32'd0;
        endcase
    end

    pie_aqm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pie_aqm_dp #(
        .MIN_QUEUE_BYTES_HALF (MIN_QUEUE_BYTES_HALF)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_cfg              (r_cfg),
        .i_action           (i_in.action),
        .i_now_ms           (i_in.now_ms),
        .i_packet_bytes     (i_in.packet_bytes),
        .i_queue_bytes      (i_in.queue_bytes),
        .i_queue_packets    (i_in.queue_packets),
        .i_random_fraction  (i_in.random_fraction),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_accept           (o_out.accept),
        .o_verdict          (o_out.verdict),
        .o_drop_probability (o_out.drop_probability),
        .o_queue_delay_ms   (o_out.queue_delay_ms),
        .o_dequeue_rate     (o_out.dequeue_rate)
    );
endmodule

@@ sv/pie_aqm_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; used by pie_aqm_dp for the rate sample and the delay estimate.
module pie_aqm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_dvs, n_dvs;
    logic [32:0] w_sh, w_diff;

    // shift, trial subtract, keep on no borrow
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        w_sh   = {r_rem[31:0], r_quo[31]};
        w_diff = w_sh - {1'b0, r_dvs};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_rem  = 33'd0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                n_rem = w_diff;
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

@@ sv/pie_aqm_ctrl.sv @@
// Sequencer of the PIE drop controller: measurement, replay loop, verdict.
// Depends on pie_aqm_pkg; drives pie_aqm_dp through t_cmd and reads t_sts.
module pie_aqm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pie_aqm_pkg::t_sts  i_sts,
    output pie_aqm_pkg::t_cmd  o_cmd
);
    pie_aqm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pie_aqm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            pie_aqm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pie_aqm_pkg::ST_MEAS;
                end
            end
            pie_aqm_pkg::ST_MEAS: begin
                // enqueues skip the rate estimator
                if (i_sts.action) begin
                    o_cmd.meas = 1'b1;
                    n_state    = pie_aqm_pkg::ST_MCHK;
                end else begin
                    n_state = pie_aqm_pkg::ST_RSTART;
                end
            end
            pie_aqm_pkg::ST_MCHK: begin
                if (i_sts.meas_due) begin
                    o_cmd.mdiv_start = 1'b1;
                    n_state          = pie_aqm_pkg::ST_MDIV;
                end else begin
                    n_state = pie_aqm_pkg::ST_RSTART;
                end
            end
            pie_aqm_pkg::ST_MDIV: begin
                if (i_sts.div_done) begin
                    n_state = pie_aqm_pkg::ST_MUPD;
                end
            end
            pie_aqm_pkg::ST_MUPD: begin
                o_cmd.mupd = 1'b1;
                n_state    = pie_aqm_pkg::ST_RSTART;
            end
            pie_aqm_pkg::ST_RSTART: begin
                o_cmd.rstart = 1'b1;
                if (!i_sts.started) begin
                    n_state = pie_aqm_pkg::ST_FINISH;
                end else if (i_sts.avg_nz && i_sts.rep_more) begin
                    o_cmd.rdiv_start = 1'b1;
                    n_state          = pie_aqm_pkg::ST_RDIV;
                end else begin
                    n_state = pie_aqm_pkg::ST_RCHK;
                end
            end
            pie_aqm_pkg::ST_RDIV: begin
                if (i_sts.div_done) begin
                    n_state = pie_aqm_pkg::ST_RCHK;
                end
            end
            pie_aqm_pkg::ST_RCHK: begin
                if (!i_sts.rep_more) begin
                    n_state = pie_aqm_pkg::ST_FINISH;
                end else if (i_sts.rep_limit) begin
                    o_cmd.rskip = 1'b1;
                    n_state     = pie_aqm_pkg::ST_FINISH;
                end else begin
                    n_state = pie_aqm_pkg::ST_PA;
                end
            end
            pie_aqm_pkg::ST_PA: begin
                o_cmd.per_a = 1'b1;
                n_state     = pie_aqm_pkg::ST_PB;
            end
            pie_aqm_pkg::ST_PB: begin
                o_cmd.per_b = 1'b1;
                n_state     = pie_aqm_pkg::ST_PC;
            end
            pie_aqm_pkg::ST_PC: begin
                o_cmd.per_c = 1'b1;
                n_state     = pie_aqm_pkg::ST_RCHK;
            end
            pie_aqm_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = pie_aqm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pie_aqm_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

@@ sv/pie_aqm_dp.sv @@
// Datapath of the PIE drop controller: controller state, period update,
// rate estimator, verdict and result register. Depends on pie_aqm_pkg, pie_aqm_div.
module pie_aqm_dp #(
    parameter int unsigned MIN_QUEUE_BYTES_HALF = 1504
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pie_aqm_pkg::t_cmd  i_cmd,
    output pie_aqm_pkg::t_sts  o_sts,
    input  pie_aqm_pkg::t_cfg  i_cfg,
    input  logic               i_action,
    input  logic [31:0]        i_now_ms,
    input  logic [15:0]        i_packet_bytes,
    input  logic [31:0]        i_queue_bytes,
    input  logic [31:0]        i_queue_packets,
    input  logic [23:0]        i_random_fraction,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_accept,
    output logic [1:0]         o_verdict,
    output logic [24:0]        o_drop_probability,
    output logic [31:0]        o_queue_delay_ms,
    output logic [31:0]        o_dequeue_rate
);
    // captured beat
    logic        r_act;
    logic [31:0] r_now, r_qb, r_qp;
    logic [15:0] r_pb;
    logic [23:0] r_rnd;

    // controller state
    logic [24:0] r_dp;
    logic [31:0] r_burst, r_prev, r_pres, r_mbytes, r_mstart, r_avg, r_last;
    logic        r_meas_on, r_started, r_upd;
    logic [10:0] r_n;
    logic [59:0] r_prod;

    // result register
    logic        r_ovalid;
    logic        r_oacc;
    logic [1:0]  r_over;
    logic [24:0] r_odp;
    logic [31:0] r_odel, r_orate;

    logic [9:0]  w_per;
    logic [31:0] w_elapsed, w_dt, w_quot, w_div_a, w_div_b;
    logic        w_div_done, w_div_start;

    assign w_per     = (i_cfg.period != 10'd0) ? i_cfg.period : 10'd1;
    assign w_elapsed = r_now - r_last;
    assign w_dt      = r_now - r_mstart;

    // divider: rate sample or delay estimate
    assign w_div_start = i_cmd.mdiv_start | i_cmd.rdiv_start;
    assign w_div_a     = i_cmd.mdiv_start ? r_mbytes : r_qb;
    assign w_div_b     = i_cmd.mdiv_start ? w_dt : r_avg;

    pie_aqm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // status
    always_comb begin
        o_sts.action    = r_act;
        o_sts.started   = r_started;
        o_sts.meas_due  = r_meas_on && (r_mbytes > i_cfg.thresh) && (w_dt != 32'd0);
        o_sts.avg_nz    = (r_avg != 32'd0);
        o_sts.rep_more  = (w_elapsed > {22'd0, w_per});
        o_sts.rep_limit = (r_n >= pie_aqm_pkg::REPLAY_LIMIT);
        o_sts.div_done  = w_div_done;
        o_sts.out_free  = !r_ovalid || i_out_ready;
    end

    // measurement start and byte count
    logic        w_mstart_now;
    logic [31:0] w_mb0;
    logic [32:0] w_mbsum;
    always_comb begin
        w_mstart_now = (r_qb >= i_cfg.thresh) && !r_meas_on;
        w_mb0        = w_mstart_now ? 32'd0 : r_mbytes;
        w_mbsum      = {1'b0, w_mb0} + {17'd0, r_pb};
    end

    // rate sample folded into the average
    logic [32:0] w_avg_sum;
    logic [31:0] w_avg_new, w_burst_dt;
    always_comb begin
        w_avg_sum = {1'b0, r_avg - (r_avg >> 3)} + {1'b0, w_quot >> 3};
        if (r_avg == 32'd0) begin
            w_avg_new = w_quot;
        end else if (w_avg_sum[32]) begin
            w_avg_new = 32'hFFFF_FFFF;
        end else begin
            w_avg_new = w_avg_sum[31:0];
        end
        w_burst_dt = (r_burst > w_dt) ? (r_burst - w_dt) : 32'd0;
    end

    // period stage A: delay estimate and probability step with clamp
    logic [31:0]        w_pres;
    logic signed [33:0] w_e1, w_e2;
    logic signed [38:0] w_s;
    logic signed [56:0] w_step, w_np;
    logic [24:0]        w_dp_a;
    logic               w_upd_a;
    always_comb begin
        w_pres  = (r_avg != 32'd0) ? w_quot : 32'd0;
        w_upd_a = !((w_pres == 32'd0) && (r_qb != 32'd0));
        w_e1    = $signed({2'b00, w_pres}) - $signed({18'd0, i_cfg.target});
        w_e2    = $signed({2'b00, w_pres}) - $signed({2'b00, r_pres});
        w_s     = 39'(w_e1) + (39'(w_e2) <<< 3) + (39'(w_e2) <<< 1);
        if (r_dp < pie_aqm_pkg::PROB_LT_001) begin
            w_step = 57'(w_s) <<< 14;
        end else if (r_dp < pie_aqm_pkg::PROB_LT_01) begin
            w_step = 57'(w_s) <<< 16;
        end else begin
            w_step = 57'(w_s) <<< 17;
        end
        w_np = $signed({32'd0, r_dp}) + w_step;
        if (w_np < 0) begin
            w_dp_a = 25'd0;
        end else if (w_np > $signed({32'd0, pie_aqm_pkg::PROB_ONE})) begin
            w_dp_a  = pie_aqm_pkg::PROB_ONE;
            w_upd_a = 1'b0;
        end else begin
            w_dp_a = w_np[24:0];
        end
    end

    // period stage B: 49/50 decay, 49x by shifts then reciprocal of 25
    logic [30:0] w_x49;
    always_comb begin
        w_x49 = (31'(r_dp) << 5) + (31'(r_dp) << 4) + 31'(r_dp);
    end

    // period stage C: apply decay, age burst, idle reset
    logic [24:0] w_dp_c;
    logic [31:0] w_half, w_burst_per;
    logic        w_idle;
    always_comb begin
        w_dp_c = ((r_pres == 32'd0) && (r_prev == 32'd0) && r_upd) ?
                 r_prod[58:34] : r_dp;
        w_half = {17'd0, i_cfg.target[15:1]};
        w_burst_per = (r_burst > {22'd0, w_per}) ? (r_burst - {22'd0, w_per}) : 32'd0;
        w_idle = (w_dp_c == 25'd0) && (r_pres < w_half) && (r_prev < w_half) &&
                 (r_avg != 32'd0);
    end

    // admission decision
    logic [32:0] w_bsum, w_psum;
    logic        w_full, w_early;
    always_comb begin
        w_bsum  = {1'b0, r_qb} + {17'd0, r_pb};
        w_psum  = {1'b0, r_qp} + 33'd1;
        w_full  = ((i_cfg.blimit != 32'd0) && (w_bsum > {1'b0, i_cfg.blimit})) ||
                  ((i_cfg.plimit != 32'd0) && (w_psum > {1'b0, i_cfg.plimit}));
        w_early = (r_burst == 32'd0) &&
                  !((r_prev < w_half) && (r_dp < pie_aqm_pkg::PROB_LT_02)) &&
                  (r_qb >= 32'(2 * MIN_QUEUE_BYTES_HALF)) &&
                  ({1'b0, r_rnd} < r_dp);
    end

    // state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp      <= 25'd0;
            r_burst   <= 32'd0;
            r_prev    <= 32'd0;
            r_pres    <= 32'd0;
            r_mbytes  <= 32'd0;
            r_meas_on <= 1'b0;
            r_mstart  <= 32'd0;
            r_avg     <= 32'd0;
            r_last    <= 32'd0;
            r_started <= 1'b0;
            r_n       <= 11'd0;
            r_upd     <= 1'b0;
            r_act     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_act <= i_action;
            end
            if (i_cmd.meas) begin
                if (w_mstart_now) begin
                    r_mstart <= r_now;
                end
                if (w_mstart_now || r_meas_on) begin
                    r_meas_on <= 1'b1;
                    r_mbytes  <= w_mbsum[32] ? 32'hFFFF_FFFF : w_mbsum[31:0];
                end
            end
            if (i_cmd.mupd) begin
                r_avg   <= w_avg_new;
                r_burst <= w_burst_dt;
                if (r_qb < i_cfg.thresh) begin
                    r_meas_on <= 1'b0;
                end else begin
                    r_mbytes <= 32'd0;
                    r_mstart <= r_now;
                end
            end
            if (i_cmd.rstart) begin
                r_n <= 11'd0;
                if (!r_started) begin
                    r_started <= 1'b1;
                    r_last    <= r_now;
                end
            end
            if (i_cmd.rskip) begin
                r_last <= r_now;
            end
            if (i_cmd.per_a) begin
                r_prev <= r_pres;
                r_pres <= w_pres;
                r_dp   <= w_dp_a;
                r_upd  <= w_upd_a;
            end
            if (i_cmd.per_c) begin
                r_dp   <= w_dp_c;
                r_last <= r_last + {22'd0, w_per};
                r_n    <= r_n + 11'd1;
                if (w_idle) begin
                    r_meas_on <= 1'b0;
                    r_avg     <= 32'd0;
                    r_burst   <= {16'd0, i_cfg.burst};
                end else begin
                    r_burst <= w_burst_per;
                end
            end
            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        // payload
        if (i_cmd.load) begin
            r_now <= i_now_ms;
            r_pb  <= i_packet_bytes;
            r_qb  <= i_queue_bytes;
            r_qp  <= i_queue_packets;
            r_rnd <= i_random_fraction;
        end
        if (i_cmd.per_b) begin
            r_prod <= 60'(w_x49[30:1]) * 60'(pie_aqm_pkg::DECAY_RECIP);
        end
        if (i_cmd.finish) begin
            r_odp   <= r_dp;
            r_odel  <= r_pres;
            r_orate <= r_avg;
            if (r_act) begin
                r_oacc <= 1'b0;
                r_over <= pie_aqm_pkg::VERDICT_DEQ;
            end else if (w_full) begin
                r_oacc <= 1'b0;
                r_over <= pie_aqm_pkg::VERDICT_FULL;
            end else if (w_early) begin
                r_oacc <= 1'b0;
                r_over <= pie_aqm_pkg::VERDICT_EARLY;
            end else begin
                r_oacc <= 1'b1;
                r_over <= pie_aqm_pkg::VERDICT_ACCEPT;
            end
        end
    end

    assign o_out_valid        = r_ovalid;
    assign o_accept           = r_oacc;
    assign o_verdict          = r_over;
    assign o_drop_probability = r_odp;
    assign o_queue_delay_ms   = r_odel;
    assign o_dequeue_rate     = r_orate;
endmodule

@@ sv/pie_aqm_chk.sv @@
// Port-level checks of the PIE drop controller, bound to the top level.
// Depends on pie_aqm_pkg for verdict codes.
module pie_aqm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_accept,
    input logic [1:0]  i_verdict,
    input logic [24:0] i_drop_probability
);
    // a result beat is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn before it was taken");

    // accept flag agrees with the verdict code
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_accept == (i_verdict == pie_aqm_pkg::VERDICT_ACCEPT)))
        else $error("accept flag disagrees with verdict");

    // probability never above one
    a_prob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_drop_probability <= pie_aqm_pkg::PROB_ONE))
        else $error("drop probability above 1.0");

    // an event taken leaves the input closed the next cycle while it is worked
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second event taken while one is in progress");
endmodule

bind pie_aqm_drop_controller pie_aqm_chk u_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_accept           (o_out.accept),
    .i_verdict          (o_out.verdict),
    .i_drop_probability (o_out.drop_probability)
);
